@@ src/vmf_pkg.sv @@
// Package for the volume median filter: state type, sizes and register indexes.
// Used by volume_median_filter_top; depends on nothing else.
`default_nettype none
package vmf_pkg;

  localparam int unsigned CoordW = 5;
  localparam int unsigned SizeW  = 6;
  localparam int unsigned HalfW  = 2;
  localparam int unsigned ValW   = 8;
  localparam int unsigned CntW   = 9;
  localparam int unsigned AddrW  = 3 * CoordW;
  localparam int unsigned HistD  = 1 << ValW;
  localparam logic [SizeW-1:0] MaxSize = 6'd32;
  localparam logic [HalfW-1:0] MaxHalf = 2'd3;

  localparam logic [2:0] RegSizeX = 3'd0;
  localparam logic [2:0] RegSizeY = 3'd1;
  localparam logic [2:0] RegSizeZ = 3'd2;
  localparam logic [2:0] RegHalfX = 3'd3;
  localparam logic [2:0] RegHalfY = 3'd4;
  localparam logic [2:0] RegHalfZ = 3'd5;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SETUP, S_WIN_RD, S_HIST_RD, S_HIST_WR, S_SCAN_RD, S_SCAN_ACC
  } state_t;

endpackage
`default_nettype wire

@@ src/volume_median_filter_top.sv @@
// 3D median filter over a stored 8-bit volume, with its volume and histogram memories.
// Depends on vmf_pkg.
`default_nettype none
// A load request (s_tuser = 0) writes one voxel. A query request (s_tuser = 1)
// walks the clipped box window through the volume memory and builds a 256-bin
// histogram with a volume read, a histogram read and a histogram write per window
// voxel, then sweeps all 256 bins, finding the median and clearing each bin for
// the next query. The next request can be taken in the same cycle in which a
// query's result becomes valid; the largest window is 7x7x7 voxels. A query also
// waits in its setup state for as long as an earlier result has not been taken by
// the sink. The input is not ready while a query is in progress. After reset the
// block clears the histogram before it accepts its first request; configuration
// writes are taken at any time. The median is the value at index floor(count/2)
// of the sorted window. A voxel that was never loaded returns an unspecified value.
module volume_median_filter_top
  import vmf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // pos_x[4:0], pos_y[9:5], pos_z[14:10], voxel_value[22:15]
  input  wire logic [0:0]  s_tuser,   // cmd[0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // median_value[7:0], window_count[16:8]
  output logic [0:0]       m_tuser,   // coord_error[0]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [5:0]  cfg_data
);

  state_t state, state_next;

  logic [SizeW-1:0] size_x, size_y, size_z;
  logic [HalfW-1:0] half_x, half_y, half_z;

  logic [CoordW-1:0] qx, qy, qz;
  logic [CoordW-1:0] xb, xe, yb, ye, zb, ze;
  logic [CoordW-1:0] ix, iy, iz;
  logic [ValW-1:0]   sweep;
  logic [CntW-1:0]   count, acc;
  logic [ValW-1:0]   med;
  logic              found;
  logic [CntW:0]     acc_sum;
  logic              win_last;

  logic [ValW-1:0]   vol_mem [2**AddrW];
  logic [ValW-1:0]   vol_q;
  logic [CntW-1:0]   hist_mem [HistD];
  logic [CntW-1:0]   hist_q;
  logic              hist_we;
  logic [ValW-1:0]   hist_wa, hist_ra;
  logic [CntW-1:0]   hist_wd;

  logic s_acc, m_acc;
  assign s_acc     = s_tvalid && s_tready;
  assign m_acc     = m_tvalid && m_tready;
  assign cfg_ready = 1'b1;

  // Clamp sizes to 1..32; half-widths already fit their maximum.
  function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v);
    logic [SizeW-1:0] r;
    r = v;
    if (v == '0) r = SizeW'(1);
    else if (v > MaxSize) r = MaxSize;
    return r;
  endfunction

  function automatic logic [CoordW-1:0] lo_edge(input logic [CoordW-1:0] p,
                                                 input logic [HalfW-1:0] h);
    return (p > CoordW'(h)) ? p - CoordW'(h) : '0;
  endfunction

  function automatic logic [CoordW-1:0] hi_edge(input logic [CoordW-1:0] p,
                                                 input logic [HalfW-1:0] h,
                                                 input logic [SizeW-1:0] s);
    logic [SizeW-1:0] e;
    e = SizeW'(p) + SizeW'(h);
    return (e > s - 1'b1) ? CoordW'(s - 1'b1) : CoordW'(e);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= MaxSize;
      size_y <= MaxSize;
      size_z <= MaxSize;
      half_x <= MaxHalf;
      half_y <= MaxHalf;
      half_z <= MaxHalf;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegSizeX: size_x <= clamp_size(cfg_data);
        RegSizeY: size_y <= clamp_size(cfg_data);
        RegSizeZ: size_z <= clamp_size(cfg_data);
        RegHalfX: half_x <= cfg_data[HalfW-1:0];
        RegHalfY: half_y <= cfg_data[HalfW-1:0];
        RegHalfZ: half_z <= cfg_data[HalfW-1:0];
        default: ;
      endcase
    end
  end

  assign win_last = (ix == xe) && (iy == ye) && (iz == ze);
  assign acc_sum  = {1'b0, acc} + {1'b0, hist_q};

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:    if (sweep == ValW'(HistD - 1)) state_next = S_IDLE;
      S_IDLE:     if (s_acc && s_tuser[0] == CmdQuery) state_next = S_SETUP;
      S_SETUP: begin
        if (!m_tvalid || m_tready) begin
          if (SizeW'(qx) >= size_x || SizeW'(qy) >= size_y || SizeW'(qz) >= size_z)
            state_next = S_IDLE;
          else
            state_next = S_WIN_RD;
        end
      end
      S_WIN_RD:   state_next = S_HIST_RD;
      S_HIST_RD:  state_next = S_HIST_WR;
      S_HIST_WR:  state_next = win_last ? S_SCAN_RD : S_WIN_RD;
      S_SCAN_RD:  state_next = S_SCAN_ACC;
      S_SCAN_ACC: begin
        if (sweep == ValW'(HistD - 1) && (!m_tvalid || m_tready)) state_next = S_IDLE;
        else if (sweep != ValW'(HistD - 1)) state_next = S_SCAN_RD;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // Handshake and histogram port controls.
  always_comb begin
    s_tready = (state == S_IDLE);
    hist_we  = 1'b0;
    hist_wa  = sweep;
    hist_wd  = '0;
    hist_ra  = sweep;
    case (state)
      S_CLEAR:    hist_we = 1'b1;
      S_HIST_RD:  hist_ra = vol_q;
      S_HIST_WR: begin
        hist_we = 1'b1;
        hist_wa = vol_q;
        hist_wd = hist_q + 1'b1;
      end
      S_SCAN_ACC: hist_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      sweep <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) sweep <= sweep + 1'b1;
      if (state == S_SCAN_ACC && state_next != S_SCAN_ACC) sweep <= sweep + 1'b1;
    end
  end

  // Query datapath.
  always_ff @(posedge clk) begin
    if (s_acc) begin
      qx <= s_tdata[4:0];
      qy <= s_tdata[9:5];
      qz <= s_tdata[14:10];
    end
    case (state)
      S_SETUP: begin
        xb <= lo_edge(qx, half_x);
        xe <= hi_edge(qx, half_x, size_x);
        yb <= lo_edge(qy, half_y);
        ye <= hi_edge(qy, half_y, size_y);
        zb <= lo_edge(qz, half_z);
        ze <= hi_edge(qz, half_z, size_z);
        ix <= lo_edge(qx, half_x);
        iy <= lo_edge(qy, half_y);
        iz <= lo_edge(qz, half_z);
        count <= '0;
        acc   <= '0;
        med   <= '0;
        found <= 1'b0;
      end
      S_HIST_WR: begin
        count <= count + 1'b1;
        if (ix == xe) begin
          ix <= xb;
          if (iy == ye) begin
            iy <= yb;
            if (iz != ze) iz <= iz + 1'b1;
          end else begin
            iy <= iy + 1'b1;
          end
        end else begin
          ix <= ix + 1'b1;
        end
      end
      S_SCAN_ACC: begin
        acc <= acc_sum[CntW-1:0];
        if (!found && acc_sum > {2'b0, count[CntW-1:1]}) begin
          med   <= sweep;
          found <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Result register; it loads when a query finishes and the previous result is gone.
  logic res_load_err, res_load_med;
  assign res_load_err = (state == S_SETUP) && (!m_tvalid || m_tready) &&
                        ((SizeW'(qx) >= size_x) || (SizeW'(qy) >= size_y) ||
                         (SizeW'(qz) >= size_z));
  assign res_load_med = (state == S_SCAN_ACC) && (sweep == ValW'(HistD - 1)) &&
                        (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load_err || res_load_med) begin
      m_tvalid <= 1'b1;
    end else if (m_acc) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load_err) begin
      m_tdata <= '0;
      m_tuser <= 1'b1;
    end else if (res_load_med) begin
      m_tdata <= {7'd0, count,
                  (!found && acc_sum > {2'b0, count[CntW-1:1]}) ? sweep : med};
      m_tuser <= 1'b0;
    end
  end

  // Volume memory: load writes, window walk reads.
  always_ff @(posedge clk) begin
    if (s_acc && s_tuser[0] == CmdLoad) vol_mem[s_tdata[14:0]] <= s_tdata[22:15];
    vol_q <= vol_mem[{iz, iy, ix}];
  end

  // Histogram memory.
  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_wa] <= hist_wd;
    hist_q <= hist_mem[hist_ra];
  end

  unused_err_chk: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[16:0] == 17'd0)
    else $error("error result carries data");

  count_chk: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[16:8] != 9'd0)
    else $error("median result with empty window");

  busy_chk: assert property (@(posedge clk) disable iff (rst)
    $past(s_acc && s_tuser[0] == CmdQuery) |-> !s_tready)
    else $error("request accepted during a query");

  hold_chk: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("pending result changed");

endmodule
`default_nettype wire
